### hdl/c_comment_stripper_unit_defines.svh
// Assertion helpers used by the checker file.
`ifndef C_COMMENT_STRIPPER_UNIT_DEFINES_SVH
`define C_COMMENT_STRIPPER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define CCS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define CCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/ccs_pkg.sv
`timescale 1ns / 1ps
package ccs_pkg;

	localparam int BLANK_W = 6;
	localparam int MAX_BLANKS_DEF = 62;
	localparam int QDEPTH = 4;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// One command from front to back: a run of spaces, a word, maybe a second word.
	typedef struct packed {
		logic [BLANK_W-1:0] blanks;
		logic [7:0] first;
		logic has_second;
		logic [7:0] second;
	} cmd_t;

	// Queue status seen by the front and back.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

### hdl/ccs_front.sv
`timescale 1ns / 1ps
module ccs_front #(
	parameter int MAX_BLANKS = ccs_pkg::MAX_BLANKS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input logic [7:0] in_byte,
	output logic cmd_push,
	output ccs_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		M_NORMAL = 3'd0,
		M_SLASH = 3'd1,
		M_STRING = 3'd2,
		M_ESCAPE = 3'd3,
		M_BLOCK = 3'd4,
		M_STAR = 3'd5,
		M_LINE = 3'd6
	} mode_t;

	mode_t mode_q, mode_d;
	logic [ccs_pkg::BLANK_W-1:0] blank_q, blank_d, blank_inc;
	logic text_q, text_d;
	logic closed_q, closed_d;
	logic emit;

	// Saturating space count
	assign blank_inc = (blank_q < ccs_pkg::BLANK_W'(MAX_BLANKS)) ?
		blank_q + ccs_pkg::BLANK_W'(1) : blank_q;

	// Classify the byte and build the command
	always_comb begin
		mode_d = mode_q;
		blank_d = blank_q;
		text_d = text_q;
		closed_d = 1'b0;
		emit = 1'b0;
		cmd.blanks = '0;
		cmd.first = in_byte;
		cmd.has_second = 1'b0;
		cmd.second = in_byte;
		if (closed_q && in_byte == ccs_pkg::CH_NL) begin
			// newline right after a close is swallowed
			blank_d = '0;
			text_d = 1'b0;
		end else begin
			case (mode_q)
				M_SLASH: begin
					if (in_byte == ccs_pkg::CH_STAR) begin
						mode_d = M_BLOCK;
					end else if (in_byte == ccs_pkg::CH_SLASH) begin
						emit = text_q;
						cmd.first = ccs_pkg::CH_NL;
						blank_d = '0;
						mode_d = M_LINE;
					end else begin
						// release the held slash, then treat byte as text
						emit = 1'b1;
						cmd.blanks = blank_q;
						cmd.first = ccs_pkg::CH_SLASH;
						blank_d = '0;
						text_d = 1'b1;
						mode_d = M_NORMAL;
						if (in_byte == ccs_pkg::CH_SPACE) begin
							blank_d = ccs_pkg::BLANK_W'(1);
						end else if (in_byte == ccs_pkg::CH_NL) begin
							cmd.has_second = 1'b1;
							text_d = 1'b0;
						end else begin
							cmd.has_second = 1'b1;
							if (in_byte == ccs_pkg::CH_QUOTE) begin
								mode_d = M_STRING;
							end
						end
					end
				end
				M_STRING, M_ESCAPE: begin
					if (mode_q == M_ESCAPE) begin
						mode_d = M_STRING;
					end
					if (in_byte == ccs_pkg::CH_SPACE) begin
						blank_d = blank_inc;
					end else if (in_byte == ccs_pkg::CH_NL) begin
						emit = 1'b1;
						blank_d = '0;
						text_d = 1'b0;
					end else begin
						emit = 1'b1;
						cmd.blanks = blank_q;
						blank_d = '0;
						text_d = 1'b1;
						if (mode_q == M_STRING) begin
							if (in_byte == ccs_pkg::CH_QUOTE) begin
								mode_d = M_NORMAL;
							end else if (in_byte == ccs_pkg::CH_BSLASH) begin
								mode_d = M_ESCAPE;
							end
						end
					end
				end
				M_BLOCK, M_STAR: begin
					if (in_byte == ccs_pkg::CH_NL) begin
						blank_d = '0;
						text_d = 1'b0;
					end
					if (mode_q == M_STAR && in_byte == ccs_pkg::CH_SLASH) begin
						mode_d = M_NORMAL;
						closed_d = 1'b1;
					end else if (in_byte == ccs_pkg::CH_STAR) begin
						mode_d = M_STAR;
					end else begin
						mode_d = M_BLOCK;
					end
				end
				M_LINE: begin
					if (in_byte == ccs_pkg::CH_NL) begin
						blank_d = '0;
						text_d = 1'b0;
						mode_d = M_NORMAL;
					end
				end
				default: begin
					// normal text, and the unused code
					mode_d = M_NORMAL;
					if (in_byte == ccs_pkg::CH_SLASH) begin
						mode_d = M_SLASH;
					end else if (in_byte == ccs_pkg::CH_SPACE) begin
						blank_d = blank_inc;
					end else if (in_byte == ccs_pkg::CH_NL) begin
						emit = 1'b1;
						blank_d = '0;
						text_d = 1'b0;
					end else begin
						emit = 1'b1;
						cmd.blanks = blank_q;
						blank_d = '0;
						text_d = 1'b1;
						if (in_byte == ccs_pkg::CH_QUOTE) begin
							mode_d = M_STRING;
						end
					end
				end
			endcase
		end
	end

	assign cmd_push = accept && emit;

	// Advance state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_NORMAL;
			blank_q <= '0;
			text_q <= 1'b0;
			closed_q <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			blank_q <= blank_d;
			text_q <= text_d;
			closed_q <= closed_d;
		end
	end

endmodule

### hdl/ccs_cmd_fifo.sv
`timescale 1ns / 1ps
module ccs_cmd_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input ccs_pkg::cmd_t wr_cmd,
	input logic pop,
	output ccs_pkg::cmd_t head,
	output ccs_pkg::q_stat_t stat
);

	localparam int PTR_W = $clog2(ccs_pkg::QDEPTH);
	localparam int CNT_W = $clog2(ccs_pkg::QDEPTH + 1);

	ccs_pkg::cmd_t slots_q [ccs_pkg::QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push, do_pop;

	assign stat.full = (count_q == CNT_W'(ccs_pkg::QDEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push = push && !stat.full;
	assign do_pop = pop && !stat.empty;
	assign head = slots_q[rd_ptr_q];

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// Move pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

### hdl/ccs_back.sv
`timescale 1ns / 1ps
module ccs_back (
	input logic clk,
	input logic arst_n,
	input ccs_pkg::cmd_t head,
	input ccs_pkg::q_stat_t stat,
	output logic q_pop,
	input logic pop,
	output logic empty,
	output logic [7:0] out_byte,
	output logic last
);

	logic valid_q;
	logic [7:0] byte_q;
	logic last_q;
	logic [ccs_pkg::BLANK_W-1:0] sent_q;
	logic second_q;
	logic step, retire;
	logic [7:0] word;
	logic word_last;

	// Take a new word when the output slot frees up
	assign step = (!valid_q || pop) && !stat.empty;

	// Pick the next word of the head command
	always_comb begin
		word = head.first;
		word_last = 1'b0;
		retire = 1'b0;
		if (sent_q != head.blanks) begin
			word = ccs_pkg::CH_SPACE;
		end else if (!second_q) begin
			word_last = !head.has_second;
			retire = !head.has_second;
		end else begin
			word = head.second;
			word_last = 1'b1;
			retire = 1'b1;
		end
	end

	assign q_pop = step && retire;

	// Track progress through the command and the output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sent_q <= '0;
			second_q <= 1'b0;
		end else if (step) begin
			valid_q <= 1'b1;
			if (retire) begin
				sent_q <= '0;
				second_q <= 1'b0;
			end else if (sent_q != head.blanks) begin
				sent_q <= sent_q + ccs_pkg::BLANK_W'(1);
			end else begin
				second_q <= 1'b1;
			end
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	// Load the output word
	always_ff @(posedge clk) begin
		if (step) begin
			byte_q <= word;
			last_q <= word_last;
		end
	end

	assign empty = !valid_q;
	assign out_byte = byte_q;
	assign last = last_q;

endmodule

### hdl/c_comment_stripper_unit.sv
`timescale 1ns / 1ps
// Channel   Handshake      Payload
// input     push / full    in_byte[7:0]
// result    pop / empty    out_byte[7:0], last
//
// One input word per cycle is accepted while full is low; the first result
// word goes through the command queue, then the output register. The back
// sends one result word per cycle while pop is high: N pending spaces (N up to
// MAX_BLANKS), then the byte, then the next byte when a held slash is released.
// A four-entry command queue decouples the sides; a stalled result blocks input
// only once four commands wait and full rises. Reset is asynchronous; all empty.
module c_comment_stripper_unit #(
	parameter int MAX_BLANKS = ccs_pkg::MAX_BLANKS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [7:0] in_byte,
	output logic empty,
	input logic pop,
	output logic [7:0] out_byte,
	output logic last
);

	ccs_pkg::cmd_t cmd, head;
	ccs_pkg::q_stat_t stat;
	logic cmd_push, q_pop, accept;

	assign full = stat.full;
	assign accept = push && !stat.full;

	ccs_front #(
		.MAX_BLANKS(MAX_BLANKS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.in_byte(in_byte),
		.cmd_push(cmd_push),
		.cmd(cmd)
	);

	ccs_cmd_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(cmd_push),
		.wr_cmd(cmd),
		.pop(q_pop),
		.head(head),
		.stat(stat)
	);

	ccs_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.stat(stat),
		.q_pop(q_pop),
		.pop(pop),
		.empty(empty),
		.out_byte(out_byte),
		.last(last)
	);

endmodule

### hdl/ccs_checker.sv
`timescale 1ns / 1ps
`include "c_comment_stripper_unit_defines.svh"
module ccs_checker (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input logic [7:0] in_byte,
	input logic empty,
	input logic pop,
	input logic [7:0] out_byte,
	input logic last
);

	// Hold a stalled result word
	`CCS_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_byte) && $stable(last), "result changed while stalled")

	// Released spaces always precede a visible word
	`CCS_ASSERT_NOW(a_space_not_last, !empty && out_byte == ccs_pkg::CH_SPACE, !last, "space word marked last")

	// A newline always closes the words of its input
	`CCS_ASSERT_NOW(a_nl_last, !empty && out_byte == ccs_pkg::CH_NL, last, "newline word not marked last")

	// A space accepted while no result word waits does not fill the queue
	`CCS_ASSERT_NEXT(a_space_quiet, push && !full && in_byte == ccs_pkg::CH_SPACE && empty && !full, !full, "space filled the queue")

endmodule

bind c_comment_stripper_unit ccs_checker u_ccs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.push(push),
	.full(full),
	.in_byte(in_byte),
	.empty(empty),
	.pop(pop),
	.out_byte(out_byte),
	.last(last)
);

### verif/c_comment_stripper_unit_test.sv
`timescale 1ns / 1ps
module c_comment_stripper_unit_test;

	localparam int ITEM_GOAL = 470;
	localparam int HOLD_OFF_CYCLES = 300;

	typedef enum logic [2:0] {
		MODE_TEXT = 3'd0,
		MODE_SLASH = 3'd1,
		MODE_STRING = 3'd2,
		MODE_ESCAPE = 3'd3,
		MODE_BLOCK = 3'd4,
		MODE_STAR = 3'd5,
		MODE_LINE = 3'd6
	} strip_mode_t;

	typedef struct {
		logic [7:0] out_byte;
		logic last;
	} text_word_t;

	// Track the stripper state and the text words it still owes.
	class strip_scoreboard;
		strip_mode_t mode;
		logic [ccs_pkg::BLANK_W-1:0] pending_blanks;
		logic line_has_text;
		logic after_close;
		text_word_t due_words[$];
		text_word_t fresh_words[$];
		int unsigned errors;
		int unsigned words_seen;

		function new();
			mode = MODE_TEXT;
			pending_blanks = '0;
			line_has_text = 1'b0;
			after_close = 1'b0;
			errors = 0;
			words_seen = 0;
		endfunction

		function void emit(logic [7:0] b);
			text_word_t w;
			w.out_byte = b;
			w.last = 1'b0;
			fresh_words.push_back(w);
		endfunction

		function void add_blank();
			if (pending_blanks < ccs_pkg::MAX_BLANKS_DEF)
				pending_blanks++;
		endfunction

		// Release the waiting spaces ahead of a visible byte.
		function void emit_visible(logic [7:0] b);
			while (pending_blanks > 0) begin
				emit(ccs_pkg::CH_SPACE);
				pending_blanks--;
			end
			emit(b);
			line_has_text = 1'b1;
		endfunction

		function void emit_newline();
			pending_blanks = '0;
			emit(ccs_pkg::CH_NL);
			line_has_text = 1'b0;
		endfunction

		function void quiet_eol();
			pending_blanks = '0;
			line_has_text = 1'b0;
		endfunction

		function void text_byte(logic [7:0] c);
			if (c == ccs_pkg::CH_SLASH) begin
				mode = MODE_SLASH;
			end else if (c == ccs_pkg::CH_SPACE) begin
				add_blank();
			end else if (c == ccs_pkg::CH_NL) begin
				emit_newline();
			end else begin
				emit_visible(c);
				if (c == ccs_pkg::CH_QUOTE)
					mode = MODE_STRING;
			end
		endfunction

		function void string_byte(logic [7:0] c);
			if (c == ccs_pkg::CH_SPACE) begin
				add_blank();
			end else if (c == ccs_pkg::CH_NL) begin
				emit_newline();
			end else begin
				emit_visible(c);
				if (c == ccs_pkg::CH_QUOTE)
					mode = MODE_TEXT;
				else if (c == ccs_pkg::CH_BSLASH)
					mode = MODE_ESCAPE;
			end
		endfunction

		// Advance the state by one accepted byte and queue the words it causes.
		function void note_input(logic [7:0] c);
			logic swallowed;
			swallowed = 1'b0;
			fresh_words.delete();
			if (after_close) begin
				after_close = 1'b0;
				if (c == ccs_pkg::CH_NL) begin
					quiet_eol();
					swallowed = 1'b1;
				end
			end
			if (!swallowed) begin
				case (mode)
					MODE_SLASH: begin
						if (c == ccs_pkg::CH_STAR) begin
							mode = MODE_BLOCK;
						end else if (c == ccs_pkg::CH_SLASH) begin
							if (line_has_text)
								emit(ccs_pkg::CH_NL);
							pending_blanks = '0;
							mode = MODE_LINE;
						end else begin
							mode = MODE_TEXT;
							emit_visible(ccs_pkg::CH_SLASH);
							text_byte(c);
						end
					end
					MODE_STRING: begin
						string_byte(c);
					end
					MODE_ESCAPE: begin
						mode = MODE_STRING;
						if (c == ccs_pkg::CH_SPACE)
							add_blank();
						else if (c == ccs_pkg::CH_NL)
							emit_newline();
						else
							emit_visible(c);
					end
					MODE_BLOCK, MODE_STAR: begin
						if (c == ccs_pkg::CH_NL)
							quiet_eol();
						if (mode == MODE_STAR && c == ccs_pkg::CH_SLASH) begin
							mode = MODE_TEXT;
							after_close = 1'b1;
						end else begin
							mode = (c == ccs_pkg::CH_STAR) ? MODE_STAR : MODE_BLOCK;
						end
					end
					MODE_LINE: begin
						if (c == ccs_pkg::CH_NL) begin
							quiet_eol();
							mode = MODE_TEXT;
						end
					end
					default: begin
						mode = MODE_TEXT;
						text_byte(c);
					end
				endcase
			end
			if (fresh_words.size() > 0)
				fresh_words[fresh_words.size() - 1].last = 1'b1;
			foreach (fresh_words[i])
				due_words.push_back(fresh_words[i]);
		endfunction

		task report_mismatch(string msg);
			$display("%0t ns word %0d: %s", $realtime, words_seen, msg);
			errors++;
		endtask

		// Compare one popped word with the oldest one owed.
		task check_word(logic [7:0] got_byte, logic got_last);
			text_word_t want;
			if (due_words.size() == 0) begin
				report_mismatch($sformatf("unexpected word 0x%02h last %0b",
					got_byte, got_last));
			end else begin
				want = due_words.pop_front();
				if (got_byte !== want.out_byte)
					report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
						got_byte, want.out_byte));
				if (got_last !== want.last)
					report_mismatch($sformatf("last %0b, expected %0b",
						got_last, want.last));
			end
			words_seen++;
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [7:0] in_byte = 8'h00;
	logic empty;
	logic pop = 1'b0;
	logic [7:0] out_byte;
	logic last;

	logic hold_off = 1'b0;
	logic sender_burst = 1'b0;
	logic receiver_burst = 1'b0;
	int items_sent = 0;
	logic [7:0] source_bytes[$];
	strip_scoreboard strip_sb;

	c_comment_stripper_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_byte(in_byte),
		.empty(empty),
		.pop(pop),
		.out_byte(out_byte),
		.last(last)
	);

	always #6 clk = ~clk;

	// Bytes inside and outside comments both count toward the goal.
	task add_live(logic [7:0] b);
		source_bytes.push_back(b);
	endtask

	task add_quiet(logic [7:0] b);
		source_bytes.push_back(b);
	endtask

	function logic [7:0] plain_char();
		logic [7:0] r;
		do begin
			r = 8'($urandom_range(33, 126));
		end while (r == ccs_pkg::CH_SLASH || r == ccs_pkg::CH_QUOTE);
		return r;
	endfunction

	// Cover byte extremes, held slash, both comment kinds, strings and escapes.
	task build_directed();
		add_live(8'h00);
		add_live(8'hFF);
		add_live(ccs_pkg::CH_SPACE);
		add_live(ccs_pkg::CH_SLASH);
		add_live("q");
		add_live(ccs_pkg::CH_SLASH);
		add_quiet(ccs_pkg::CH_STAR);
		add_quiet(ccs_pkg::CH_SLASH);
		add_quiet(ccs_pkg::CH_NL);
		add_quiet(ccs_pkg::CH_STAR);
		add_quiet(ccs_pkg::CH_SLASH);
		add_quiet(ccs_pkg::CH_NL);
		add_live(ccs_pkg::CH_QUOTE);
		add_live(ccs_pkg::CH_SPACE);
		add_live(ccs_pkg::CH_BSLASH);
		add_live(ccs_pkg::CH_QUOTE);
		add_live(ccs_pkg::CH_BSLASH);
		add_live(ccs_pkg::CH_NL);
		add_live(ccs_pkg::CH_QUOTE);
		add_live(ccs_pkg::CH_SLASH);
		add_live(ccs_pkg::CH_SLASH);
		add_quiet("z");
		add_quiet(ccs_pkg::CH_NL);
		add_live(ccs_pkg::CH_SLASH);
		add_live(ccs_pkg::CH_SLASH);
		add_quiet(ccs_pkg::CH_NL);
		add_live(ccs_pkg::CH_NL);
	endtask

	// Run of spaces past the saturation bound, then maybe a held slash, and a byte.
	task add_blank_flood();
		int n;
		n = $urandom_range(ccs_pkg::MAX_BLANKS_DEF + 1, ccs_pkg::MAX_BLANKS_DEF + 8);
		repeat (n) add_live(ccs_pkg::CH_SPACE);
		if ($urandom_range(0, 1))
			add_live(ccs_pkg::CH_SLASH);
		add_live(plain_char());
	endtask

	// Mostly well-formed source with random content, some noise.
	task build_random();
		int pick;
		int n;
		int sel;
		add_blank_flood();
		while (source_bytes.size() < ITEM_GOAL) begin
			pick = $urandom_range(0, 199);
			if (pick < 50) begin
				n = $urandom_range(1, 6);
				repeat (n) add_live(plain_char());
			end else if (pick < 80) begin
				n = $urandom_range(1, 4);
				repeat (n) add_live(ccs_pkg::CH_SPACE);
			end else if (pick < 100) begin
				add_live(ccs_pkg::CH_NL);
			end else if (pick < 124) begin
				add_live(ccs_pkg::CH_QUOTE);
				n = $urandom_range(0, 8);
				repeat (n) begin
					sel = $urandom_range(0, 9);
					if (sel < 2) begin
						add_live(ccs_pkg::CH_SPACE);
					end else if (sel < 4) begin
						add_live(ccs_pkg::CH_BSLASH);
						case ($urandom_range(0, 4))
							0: add_live(ccs_pkg::CH_QUOTE);
							1: add_live(ccs_pkg::CH_BSLASH);
							2: add_live(ccs_pkg::CH_NL);
							3: add_live(ccs_pkg::CH_SPACE);
							default: add_live(8'($urandom_range(0, 255)));
						endcase
					end else if (sel == 4) begin
						add_live(ccs_pkg::CH_NL);
					end else begin
						add_live(plain_char());
					end
				end
				add_live(ccs_pkg::CH_QUOTE);
			end else if (pick < 148) begin
				add_live(ccs_pkg::CH_SLASH);
				add_quiet(ccs_pkg::CH_STAR);
				n = $urandom_range(0, 10);
				repeat (n) begin
					case ($urandom_range(0, 4))
						0: add_quiet(ccs_pkg::CH_STAR);
						1: add_quiet(ccs_pkg::CH_SLASH);
						2: add_quiet(ccs_pkg::CH_SPACE);
						3: add_quiet(ccs_pkg::CH_NL);
						default: add_quiet(8'($urandom_range(0, 255)));
					endcase
				end
				add_quiet(ccs_pkg::CH_STAR);
				add_quiet(ccs_pkg::CH_SLASH);
				if ($urandom_range(0, 1))
					add_quiet(ccs_pkg::CH_NL);
			end else if (pick < 168) begin
				add_live(ccs_pkg::CH_SLASH);
				add_live(ccs_pkg::CH_SLASH);
				n = $urandom_range(0, 8);
				repeat (n) add_quiet($urandom_range(0, 1) ? ccs_pkg::CH_SPACE : plain_char());
				add_quiet(ccs_pkg::CH_NL);
			end else if (pick < 176) begin
				add_live(ccs_pkg::CH_SLASH);
				add_live(8'($urandom_range(0, 255)));
			end else if (pick < 198) begin
				add_live(8'($urandom_range(0, 255)));
			end else begin
				add_blank_flood();
			end
		end
	endtask

	// Offer one byte after a random gap; hold it until accepted.
	task send_byte(logic [7:0] b);
		int gap;
		gap = sender_burst ? 0 : $urandom_range(0, 4);
		if ($urandom_range(0, 39) == 0)
			sender_burst = !sender_burst;
		if (gap > 0) begin
			push = 1'b0;
			repeat (gap) @(negedge clk);
		end
		push = 1'b1;
		in_byte = b;
		do begin
			@(posedge clk);
		end while (full);
		strip_sb.note_input(b);
		items_sent++;
		@(negedge clk);
	endtask

	// Pop words with random stalls and check each one.
	task take_words();
		int gap;
		forever begin
			gap = receiver_burst ? 0 : $urandom_range(0, 4);
			if ($urandom_range(0, 39) == 0)
				receiver_burst = !receiver_burst;
			if (gap > 0) begin
				pop = 1'b0;
				repeat (gap) @(negedge clk);
			end
			while (hold_off) begin
				pop = 1'b0;
				@(negedge clk);
			end
			pop = 1'b1;
			do begin
				@(posedge clk);
			end while (empty);
			strip_sb.check_word(out_byte, last);
			@(negedge clk);
		end
	endtask

	// Stop popping for a long stretch so the input side backs up.
	task hold_back_receiver();
		wait (items_sent >= 150);
		hold_off = 1'b1;
		repeat (HOLD_OFF_CYCLES) @(negedge clk);
		hold_off = 1'b0;
	endtask

	initial begin
		strip_sb = new();
		build_directed();
		build_random();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		fork
			take_words();
			hold_back_receiver();
		join_none
		foreach (source_bytes[i])
			send_byte(source_bytes[i]);
		push = 1'b0;
		while (strip_sb.due_words.size() != 0)
			@(posedge clk);
		repeat (ccs_pkg::MAX_BLANKS_DEF + 16) @(posedge clk);
		if (strip_sb.errors == 0)
			$display("c_comment_stripper_unit: match");
		else
			$display("c_comment_stripper_unit: mismatch");
		$finish;
	end

	// Give up if the run stalls.
	initial begin
		#(64'd800_000 * 12);
		$display("c_comment_stripper_unit: mismatch");
		$finish;
	end

endmodule

### filelist.f
+incdir+hdl
hdl/ccs_pkg.sv
hdl/ccs_front.sv
hdl/ccs_cmd_fifo.sv
hdl/ccs_back.sv
hdl/c_comment_stripper_unit.sv
hdl/ccs_checker.sv
verif/c_comment_stripper_unit_test.sv
